>>> rtl/accessory_id_detector_assert.svh
// Assertion macros for the accessory ID detector.
// Each macro expects clk and rst_n to be visible at the point of use.
`ifndef ACCESSORY_ID_DETECTOR_ASSERT_SVH
`define ACCESSORY_ID_DETECTOR_ASSERT_SVH

`ifndef SYNTHESIS

`define ACC_ID_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("accessory_id_detector: assertion failed");

`define ACC_ID_ASSERT_NEVER(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("accessory_id_detector: forbidden condition seen");

`else

`define ACC_ID_ASSERT(label, prop)

`define ACC_ID_ASSERT_NEVER(label, cond)

`endif

`endif

>>> rtl/acc_id_pkg.sv
package acc_id_pkg;

    localparam int SAMPLES     = 5;
    localparam int DIVISOR     = SAMPLES - 2;
    localparam int ADC_W       = 12;
    localparam int ADC_MAX     = (1 << ADC_W) - 1;
    localparam int CNT_W       = $clog2(SAMPLES);
    localparam int SUM_W       = $clog2(SAMPLES * ADC_MAX + 1);
    localparam int TRIM_W      = $clog2(DIVISOR * ADC_MAX + 1);
    localparam int RECIP_SHIFT = TRIM_W + $clog2(DIVISOR);
    localparam int RECIP_W     = TRIM_W + 1;
    localparam int RECIP       = ((1 << RECIP_SHIFT) + DIVISOR - 1) / DIVISOR;
    localparam int PROD_W      = TRIM_W + RECIP_W;

    // Classification windows, all exclusive at both ends
    localparam logic [12:0] OTG_LO   = 13'd2600;
    localparam logic [12:0] OTG_HI   = 13'd2800;
    localparam logic [12:0] LOUT1_LO = 13'd1100;
    localparam logic [12:0] LOUT1_HI = 13'd1300;
    localparam logic [12:0] LOUT2_LO = 13'd3000;
    localparam logic [12:0] LOUT2_HI = 13'd4100;
    localparam logic [12:0] LOUT3_LO = 13'd1600;
    localparam logic [12:0] LOUT3_HI = 13'd2300;
    localparam logic [12:0] CAR_LO   = 13'd1300;
    localparam logic [12:0] CAR_HI   = 13'd1500;

    localparam logic       KIND_LEVEL  = 1'b0;
    localparam logic       KIND_SAMPLE = 1'b1;
    localparam logic       EVT_ONLINE  = 1'b0;
    localparam logic       EVT_OFFLINE = 1'b1;
    localparam logic [2:0] ACC_UNKNOWN = 3'd4;

    typedef enum logic [1:0] {
        LVL_LOW     = 2'd0,
        LVL_HIGH    = 2'd1,
        LVL_UNKNOWN = 2'd2
    } level_t;

    typedef enum logic [1:0] {
        TYPE_NONE     = 2'd0,
        TYPE_OTG      = 2'd1,
        TYPE_LINEOUT  = 2'd2,
        TYPE_CARMOUNT = 2'd3
    } acc_type_t;

    typedef enum logic [1:0] {
        SW_KEEP = 2'd0,
        SW_ON   = 2'd1,
        SW_OFF  = 2'd2
    } sw_cmd_t;

    typedef struct packed {
        logic arm;
        logic abort;
        logic take;
    } cap_ctrl_t;

    typedef struct packed {
        logic             done;
        logic [ADC_W-1:0] mean;
    } cap_stat_t;

    typedef struct packed {
        logic      hit;
        logic      zero;
        acc_type_t acc_type;
    } class_t;

endpackage

>>> rtl/acc_id_capture.sv
module acc_id_capture (
    input  logic                  clk,
    input  logic                  rst_n,
    input  acc_id_pkg::cap_ctrl_t ctrl,
    input  logic [11:0]           adc_sample,
    output acc_id_pkg::cap_stat_t stat
);
    import acc_id_pkg::*;

    logic              capturing_reg;
    logic              capturing_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic [SUM_W-1:0]  sum_reg;
    logic [SUM_W-1:0]  sum_next;
    logic [ADC_W-1:0]  min_reg;
    logic [ADC_W-1:0]  min_next;
    logic [ADC_W-1:0]  max_reg;
    logic [ADC_W-1:0]  max_next;
    logic              first;
    logic              last;
    logic              take;
    logic [TRIM_W-1:0] trimmed;
    logic [PROD_W-1:0] product;

    assign first = (count_reg == '0);
    assign last  = (count_reg == CNT_W'(SAMPLES - 1));
    assign take  = ctrl.take && capturing_reg;

    // First sample of a run seeds sum, minimum and maximum
    assign sum_next = first ? SUM_W'(adc_sample) : sum_reg + SUM_W'(adc_sample);
    assign min_next = (first || adc_sample < min_reg) ? adc_sample : min_reg;
    assign max_next = (first || adc_sample > max_reg) ? adc_sample : max_reg;

    // Divide by the trimmed count through a rounded-up reciprocal
    assign trimmed = TRIM_W'(sum_next - SUM_W'(min_next) - SUM_W'(max_next));
    assign product = PROD_W'(trimmed) * PROD_W'(RECIP);

    assign stat.done = take && last;
    assign stat.mean = product[RECIP_SHIFT +: ADC_W];

    always_comb
    begin
        capturing_next = capturing_reg;
        count_next     = count_reg;
        if (ctrl.arm)
        begin
            capturing_next = 1'b1;
            count_next     = '0;
        end
        else if (ctrl.abort)
        begin
            capturing_next = 1'b0;
            count_next     = '0;
        end
        else if (take)
        begin
            if (last)
            begin
                capturing_next = 1'b0;
                count_next     = '0;
            end
            else
            begin
                count_next = count_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capturing_reg <= 1'b0;
            count_reg     <= '0;
        end
        else
        begin
            capturing_reg <= capturing_next;
            count_reg     <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            sum_reg <= sum_next;
            min_reg <= min_next;
            max_reg <= max_next;
        end
    end

endmodule

>>> rtl/acc_id_class.sv
module acc_id_class (
    input  logic [11:0]        mean,
    output acc_id_pkg::class_t cls
);
    import acc_id_pkg::*;

    logic [12:0] m;
    logic        in_otg;
    logic        in_lout;
    logic        in_car;

    assign m = {1'b0, mean};

    assign in_otg  = (m > OTG_LO) && (m < OTG_HI);
    assign in_lout = ((m > LOUT1_LO) && (m < LOUT1_HI))
                  || ((m > LOUT2_LO) && (m < LOUT2_HI))
                  || ((m > LOUT3_LO) && (m < LOUT3_HI));
    assign in_car  = (m > CAR_LO) && (m < CAR_HI);

    always_comb
    begin
        cls.zero     = (mean == '0);
        cls.hit      = in_otg || in_lout || in_car;
        cls.acc_type = TYPE_NONE;
        if (in_otg)
            cls.acc_type = TYPE_OTG;
        else if (in_lout)
            cls.acc_type = TYPE_LINEOUT;
        else if (in_car)
            cls.acc_type = TYPE_CARMOUNT;
    end

endmodule

>>> rtl/accessory_id_detector.sv
// Accessory ID detector for a connector ID line.
// Request channel (item_valid / item_stall): kind selects an ID-pin level
// event (id_level) or an ADC sample (adc_sample). A request is taken at a
// clock edge with item_valid high and item_stall low.
// Result channel (result_valid / result_stall): at most one result per
// request: attach or detach, accessory code, trimmed-mean level and the
// OTG, line-out and car-dock commands. Requests that cause no result
// (repeated level, stray sample, out-of-window mean) are dropped silently.
// A result is offered once its request has passed the input register and
// then the result register. Throughput: one request per cycle while
// item_stall is low; all work for a request is one pass from the input
// register through the capture datapath, the reciprocal multiply and the
// window compares.
// While result_stall holds a waiting result, the input register keeps its
// request and item_stall rises; a request with no result still waits for
// the result register to be free.
// Reset clears the stored accessory, marks the pin level unknown and
// abandons any capture; both channels come up empty.
module accessory_id_detector (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    output logic        item_stall,
    input  logic        kind,
    input  logic        id_level,
    input  logic [11:0] adc_sample,
    output logic        result_valid,
    input  logic        result_stall,
    output logic        event_res,
    output logic [2:0]  accessory,
    output logic [11:0] measured_level,
    output logic [1:0]  otg_change,
    output logic [1:0]  line_out_switch,
    output logic        car_dock
);
    import acc_id_pkg::*;

    `include "accessory_id_detector_assert.svh"

    logic        in_valid_reg;
    logic        in_valid_next;
    logic        in_kind_reg;
    logic        in_level_reg;
    logic [11:0] in_sample_reg;
    level_t      last_level_reg;
    level_t      last_level_next;
    acc_type_t   type_reg;
    acc_type_t   type_next;

    logic        res_valid_reg;
    logic        res_valid_next;
    logic        res_event_reg;
    logic [2:0]  res_acc_reg;
    logic [11:0] res_level_reg;
    logic [1:0]  res_otg_reg;
    logic [1:0]  res_lout_reg;
    logic        res_car_reg;

    logic        advance;
    logic        fire;
    logic        accept;
    level_t      item_lvl;
    logic        level_new;
    logic        detach;
    logic        attach;
    logic        has_result;
    cap_ctrl_t   cap_ctrl;
    cap_stat_t   cap_stat;
    class_t      cls;

    logic        out_event;
    logic [2:0]  out_acc;
    logic [11:0] out_level;
    sw_cmd_t     out_otg;
    sw_cmd_t     out_lout;
    logic        out_car;

    assign advance    = !res_valid_reg || !result_stall;
    assign fire       = in_valid_reg && advance;
    assign item_stall = in_valid_reg && !advance;
    assign accept     = item_valid && !item_stall;

    assign item_lvl  = in_level_reg ? LVL_HIGH : LVL_LOW;
    assign level_new = (in_kind_reg == KIND_LEVEL) && (last_level_reg != item_lvl);

    assign cap_ctrl.arm   = fire && level_new && !in_level_reg;
    assign cap_ctrl.abort = fire && level_new && in_level_reg;
    assign cap_ctrl.take  = fire && (in_kind_reg == KIND_SAMPLE);

    acc_id_capture u_capture (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (cap_ctrl),
        .adc_sample (in_sample_reg),
        .stat       (cap_stat)
    );

    acc_id_class u_class (
        .mean (cap_stat.mean),
        .cls  (cls)
    );

    // A zero mean counts as a detach
    assign detach     = cap_ctrl.abort || (cap_stat.done && cls.zero);
    assign attach     = cap_stat.done && cls.hit;
    assign has_result = detach || attach;

    always_comb
    begin
        type_next       = type_reg;
        last_level_next = last_level_reg;
        if (fire && level_new)
            last_level_next = item_lvl;

        if (detach)
        begin
            out_event = EVT_OFFLINE;
            out_acc   = (type_reg == TYPE_NONE) ? ACC_UNKNOWN : {1'b0, type_reg};
            out_level = '0;
            out_otg   = (type_reg == TYPE_OTG) ? SW_OFF : SW_KEEP;
            out_lout  = (type_reg == TYPE_LINEOUT) ? SW_OFF : SW_KEEP;
            out_car   = 1'b0;
            type_next = TYPE_NONE;
        end
        else
        begin
            out_event = EVT_ONLINE;
            out_acc   = {1'b0, cls.acc_type};
            out_level = cap_stat.mean;
            out_otg   = (cls.acc_type == TYPE_OTG) ? SW_ON : SW_KEEP;
            out_lout  = (cls.acc_type == TYPE_LINEOUT) ? SW_ON : SW_KEEP;
            out_car   = (cls.acc_type == TYPE_CARMOUNT);
            if (attach)
                type_next = cls.acc_type;
        end
    end

    always_comb
    begin
        if (accept)
            in_valid_next = 1'b1;
        else if (advance)
            in_valid_next = 1'b0;
        else
            in_valid_next = in_valid_reg;

        res_valid_next = advance ? has_result : res_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            res_valid_reg  <= 1'b0;
            last_level_reg <= LVL_UNKNOWN;
            type_reg       <= TYPE_NONE;
        end
        else
        begin
            in_valid_reg   <= in_valid_next;
            res_valid_reg  <= res_valid_next;
            last_level_reg <= last_level_next;
            type_reg       <= type_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_kind_reg   <= kind;
            in_level_reg  <= id_level;
            in_sample_reg <= adc_sample;
        end
        if (has_result)
        begin
            res_event_reg <= out_event;
            res_acc_reg   <= out_acc;
            res_level_reg <= out_level;
            res_otg_reg   <= out_otg;
            res_lout_reg  <= out_lout;
            res_car_reg   <= out_car;
        end
    end

    assign result_valid    = res_valid_reg;
    assign event_res       = res_event_reg;
    assign accessory       = res_acc_reg;
    assign measured_level  = res_level_reg;
    assign otg_change      = res_otg_reg;
    assign line_out_switch = res_lout_reg;
    assign car_dock        = res_car_reg;

    `ACC_ID_ASSERT(a_detach_fields,
        (res_valid_reg && res_event_reg == EVT_OFFLINE)
        |-> (res_level_reg == '0 && !res_car_reg))
    `ACC_ID_ASSERT(a_attach_otg,
        (res_valid_reg && res_event_reg == EVT_ONLINE)
        |-> ((res_otg_reg == SW_ON) == (res_acc_reg == {1'b0, TYPE_OTG})))
    `ACC_ID_ASSERT(a_attach_stored,
        (res_valid_reg && res_event_reg == EVT_ONLINE)
        |-> (res_acc_reg == {1'b0, type_reg}))
    `ACC_ID_ASSERT_NEVER(a_single_off,
        res_valid_reg && res_otg_reg == SW_OFF && res_lout_reg == SW_OFF)

endmodule

>>> bench/accessory_id_detector_tb.sv
`timescale 1ns / 1ps

module accessory_id_detector_tb;
    import acc_id_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int PRINT_LIMIT    = 40;

    typedef struct {
        logic        evt;
        logic [2:0]  acc;
        logic [11:0] lvl;
        sw_cmd_t     otg;
        sw_cmd_t     lout;
        logic        car;
    } acc_report_t;

    // Tracks pin level, stored accessory and capture state; holds the
    // reports still owed by the detector in order.
    class accessory_scoreboard;
        level_t      pin_level   = LVL_UNKNOWN;
        acc_type_t   stored_type = TYPE_NONE;
        bit          armed       = 1'b0;
        int          n_taken     = 0;
        int          sum         = 0;
        int          lo          = 0;
        int          hi          = 0;
        int          errors      = 0;
        acc_report_t owed[$];

        task report_mismatch(input string msg);
            errors++;
            if (errors <= PRINT_LIMIT)
                $display("%0t ns: mismatch: %s", $time, msg);
        endtask

        function void owe_detach();
            acc_report_t r;
            r.evt  = EVT_OFFLINE;
            r.acc  = (stored_type == TYPE_NONE) ? ACC_UNKNOWN : {1'b0, stored_type};
            r.lvl  = '0;
            r.otg  = (stored_type == TYPE_OTG) ? SW_OFF : SW_KEEP;
            r.lout = (stored_type == TYPE_LINEOUT) ? SW_OFF : SW_KEEP;
            r.car  = 1'b0;
            owed.push_back(r);
            stored_type = TYPE_NONE;
        endfunction

        function void classify_mean(input int m);
            acc_report_t r;
            acc_type_t   t;
            if (m == 0) begin
                owe_detach();
                return;
            end
            r.evt  = EVT_ONLINE;
            r.lvl  = m[11:0];
            r.otg  = SW_KEEP;
            r.lout = SW_KEEP;
            r.car  = 1'b0;
            if (m > OTG_LO && m < OTG_HI) begin
                t     = TYPE_OTG;
                r.otg = SW_ON;
            end else if ((m > LOUT1_LO && m < LOUT1_HI) || (m > LOUT2_LO && m < LOUT2_HI) ||
                         (m > LOUT3_LO && m < LOUT3_HI)) begin
                t      = TYPE_LINEOUT;
                r.lout = SW_ON;
            end else if (m > CAR_LO && m < CAR_HI) begin
                t     = TYPE_CARMOUNT;
                r.car = 1'b1;
            end else begin
                return;
            end
            r.acc       = {1'b0, t};
            stored_type = t;
            owed.push_back(r);
        endfunction

        // Returns 1 when the request does something beyond being dropped.
        function bit note_request(input logic k, input logic l, input logic [11:0] s);
            level_t lv;
            int     x;
            x = s;
            if (k == KIND_LEVEL) begin
                lv = l ? LVL_HIGH : LVL_LOW;
                if (lv == pin_level)
                    return 1'b0;
                pin_level = lv;
                n_taken   = 0;
                if (lv == LVL_HIGH) begin
                    armed = 1'b0;
                    owe_detach();
                end else begin
                    armed = 1'b1;
                    sum   = 0;
                    lo    = 0;
                    hi    = 0;
                end
                return 1'b1;
            end
            if (!armed)
                return 1'b0;
            sum += x;
            if (n_taken == 0) begin
                lo = x;
                hi = x;
            end else begin
                if (x > hi) hi = x;
                if (x < lo) lo = x;
            end
            n_taken++;
            if (n_taken < SAMPLES)
                return 1'b1;
            armed   = 1'b0;
            n_taken = 0;
            classify_mean((sum - lo - hi) / DIVISOR);
            return 1'b1;
        endfunction

        task check_report(input logic evt, input logic [2:0] acc, input logic [11:0] lvl,
                          input logic [1:0] otg, input logic [1:0] lout, input logic car);
            acc_report_t e;
            if (owed.size() == 0) begin
                report_mismatch("report with none expected");
                return;
            end
            e = owed.pop_front();
            if (evt !== e.evt)
                report_mismatch($sformatf("event_res %0d, want %0d", evt, e.evt));
            if (acc !== e.acc)
                report_mismatch($sformatf("accessory %0d, want %0d", acc, e.acc));
            if (lvl !== e.lvl)
                report_mismatch($sformatf("measured_level %0d, want %0d", lvl, e.lvl));
            if (otg !== e.otg)
                report_mismatch($sformatf("otg_change %0d, want %0d", otg, e.otg));
            if (lout !== e.lout)
                report_mismatch($sformatf("line_out_switch %0d, want %0d", lout, e.lout));
            if (car !== e.car)
                report_mismatch($sformatf("car_dock %0d, want %0d", car, e.car));
        endtask
    endclass

    logic        clk = 1'b0;
    logic        rst_n;
    logic        item_valid;
    logic        item_stall;
    logic        kind;
    logic        id_level;
    logic [11:0] adc_sample;
    logic        result_valid;
    logic        result_stall;
    logic        event_res;
    logic [2:0]  accessory;
    logic [11:0] measured_level;
    logic [1:0]  otg_change;
    logic [1:0]  line_out_switch;
    logic        car_dock;

    accessory_scoreboard sb;
    int idle_pct    = 0;
    int stall_pct   = 0;
    int counted     = 0;
    int idle_cycles = 0;

    accessory_id_detector DUT (
        .clk             (clk),
        .rst_n           (rst_n),
        .item_valid      (item_valid),
        .item_stall      (item_stall),
        .kind            (kind),
        .id_level        (id_level),
        .adc_sample      (adc_sample),
        .result_valid    (result_valid),
        .result_stall    (result_stall),
        .event_res       (event_res),
        .accessory       (accessory),
        .measured_level  (measured_level),
        .otg_change      (otg_change),
        .line_out_switch (line_out_switch),
        .car_dock        (car_dock)
    );

    always #10 clk = ~clk;

    // Result side: check what was taken at this edge, then pick the next stall.
    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
            sb.check_report(event_res, accessory, measured_level, otg_change,
                            line_out_switch, car_dock);
        result_stall <= ($urandom_range(99) < stall_pct);
    end

    always @(posedge clk)
    begin
        if (!rst_n || (item_valid && !item_stall) || (result_valid && !result_stall)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    // Called just after a rising edge; returns just after the edge that took the request.
    task automatic send_request(input logic k, input logic l, input logic [11:0] s);
        while ($urandom_range(99) < idle_pct) begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid <= 1'b1;
        kind       <= k;
        id_level   <= l;
        adc_sample <= s;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        if (sb.note_request(k, l, s))
            counted++;
    endtask

    task automatic send_level(input logic l);
        send_request(KIND_LEVEL, l, 12'($urandom));
    endtask

    task automatic send_sample(input int v);
        send_request(KIND_SAMPLE, 1'($urandom), v[11:0]);
    endtask

    function automatic int pick_mean();
        int edges[9] = '{1100, 1300, 1500, 1600, 2300, 2600, 2800, 3000, 4100};
        case ($urandom_range(7))
            0: return $urandom_range(2);
            1: return edges[$urandom_range(8)] + int'($urandom_range(4)) - 2;
            2: return $urandom_range(2799, 2601);
            3: return $urandom_range(1299, 1101);
            4: return $urandom_range(4095, 3001);
            5: return $urandom_range(2299, 1601);
            6: return $urandom_range(1499, 1301);
            default: return $urandom_range(4095);
        endcase
    endfunction

    function automatic int sample_near(input int t, input int spread);
        int v;
        v = t + int'($urandom_range(2 * spread)) - spread;
        if (v < 0) v = 0;
        if (v > 4095) v = 4095;
        return v;
    endfunction

    // Mostly clean attach captures with random content; some aborted, some noise.
    task automatic random_sequence();
        int  t;
        int  spread;
        int  cut;
        bit  wild;
        if ($urandom_range(99) < 75) begin
            if (sb.pin_level != LVL_HIGH || $urandom_range(3) == 0)
                send_level(1'b1);
            send_level(1'b0);
            t      = pick_mean();
            spread = ($urandom_range(3) == 0) ? 0 : $urandom_range(40);
            wild   = ($urandom_range(4) == 0);
            cut    = ($urandom_range(19) == 0) ? $urandom_range(SAMPLES - 1) : SAMPLES;
            for (int i = 0; i < SAMPLES; i++) begin
                if (i == cut) begin
                    send_level(1'b1);
                    break;
                end
                if (wild && i == 1)
                    send_sample(0);
                else if (wild && i == 3)
                    send_sample(4095);
                else
                    send_sample(sample_near(t, spread));
            end
        end else begin
            send_request(1'($urandom), 1'($urandom), 12'($urandom));
        end
    endtask

    task automatic run_phase(input int n, input int idle, input int stall);
        int target;
        idle_pct  = idle;
        stall_pct = stall;
        target    = counted + n;
        while (counted < target)
            random_sequence();
    endtask

    initial
    begin
        sb = new;
        rst_n        <= 1'b0;
        item_valid   <= 1'b0;
        kind         <= KIND_LEVEL;
        id_level     <= 1'b0;
        adc_sample   <= '0;
        result_stall <= 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // stray sample, first detach with nothing stored, repeated levels
        send_sample(4095);
        send_level(1'b1);
        send_level(1'b1);
        send_level(1'b0);
        send_level(1'b0);
        // trimmed extremes around an OTG mean, then its detach
        send_sample(0);
        send_sample(2700);
        send_sample(2700);
        send_sample(2700);
        send_sample(4095);
        send_level(1'b1);
        // high level in the middle of a capture
        send_level(1'b0);
        repeat (3) send_sample(1400);
        send_level(1'b1);
        // zero mean goes down the detach path while the pin stays low
        send_level(1'b0);
        send_sample(0);
        send_sample(0);
        send_sample(0);
        send_sample(1);
        send_sample(1);
        send_level(1'b0);
        send_level(1'b1);
        // mean on a window edge: no report
        send_level(1'b0);
        repeat (5) send_sample(2800);

        run_phase(140, 0, 0);
        run_phase(140, 74, 0);
        run_phase(140, 0, 74);
        run_phase(140, 13, 13);

        item_valid <= 1'b0;
        while (sb.owed.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (sb.errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule
